[rtl/arf_pkg.sv]
package arf_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgRotConst = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInnerRad = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgOuterRad = 2'd2;

  // Data that rides along with the divider lanes.
  typedef struct packed {
    logic                    band;
    logic                    neg_tx;
    logic                    neg_ty;
    logic signed [DataW-1:0] fx;
    logic signed [DataW-1:0] fy;
  } arf_side_t;

  // Data that rides along with the square root pipeline.
  typedef struct packed {
    arf_side_t          side;
    logic [2*DataW-1:0] prod_x;
    logic [2*DataW-1:0] prod_y;
  } arf_root_side_t;

endpackage

[rtl/arf_if.sv]
interface arf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] force_x_in;
  logic signed [31:0] force_y_in;

  modport source(output valid, output pos_x, output pos_y, output force_x_in,
                 output force_y_in, input ready);
  modport sink(input valid, input pos_x, input pos_y, input force_x_in,
               input force_y_in, output ready);
endinterface

interface arf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_x_out;
  logic signed [31:0] force_y_out;
  logic               in_band;
  logic               saturated;

  modport source(output valid, output force_x_out, output force_y_out,
                 output in_band, output saturated, input ready);
  modport sink(input valid, input force_x_out, input force_y_out,
               input in_band, input saturated, output ready);
endinterface

[rtl/annular_rotational_force.sv]
// Annular rotational force unit.
// Particles enter on in_i (position and running force sums) and leave on
// out_o (updated forces, in-band flag, saturation flag), one word out per
// word in, in order. Both channels use a valid/ready handshake.
// The three registers (rotation constant, inner and outer radius) are
// written through cfg_we_i, cfg_idx_i and cfg_data_i; the user must
// write them only while no particle is in flight, and the block itself
// does not enforce this; writes to an unused index are ignored.
// Throughput is one particle per cycle while the receiver does not stall.
// A word passes through 68 register stages: input, square and product,
// sum, 32 stages of the digit-by-digit square root, 32 stages of the two
// restoring divider lanes, and the final add-and-saturate stage.
// When the receiver stalls, the whole pipeline freezes in place and
// in_i.ready drops in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and the registers to zero.
module annular_rotational_force (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [arf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [arf_pkg::DataW-1:0]      cfg_data_i,
  arf_in_if.sink                         in_i,
  arf_out_if.source                      out_o
);
  import arf_pkg::*;

  logic en;

  logic signed [31:0] rot_q;
  logic [31:0]        inner_q, outer_q, cmag_q;
  logic [63:0]        in2_q, out2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q   <= '0;
      inner_q <= '0;
      outer_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgRotConst: rot_q   <= cfg_data_i;
        CfgInnerRad: inner_q <= cfg_data_i;
        CfgOuterRad: outer_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    cmag_q <= rot_q[31] ? 32'(-rot_q) : 32'(rot_q);
    in2_q  <= inner_q * inner_q;
    out2_q <= outer_q * outer_q;
  end

  // Stage 1: input register and magnitudes.
  logic        v1_q;
  logic [31:0] ax1_q, ay1_q;
  logic        nx1_q, ny1_q;
  logic signed [31:0] fx1_q, fy1_q;

  // Stage 2: squares and products.
  logic        v2_q;
  logic [63:0] sqx2_q, sqy2_q, px2_q, py2_q;
  logic        ntx2_q, nty2_q;
  logic signed [31:0] fx2_q, fy2_q;

  // Stage 3: squared radius.
  logic        v3_q;
  logic [63:0] s3_q, px3_q, py3_q;
  logic        ntx3_q, nty3_q;
  logic signed [31:0] fx3_q, fy3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax1_q  <= in_i.pos_x[31] ? 32'(-in_i.pos_x) : 32'(in_i.pos_x);
      ay1_q  <= in_i.pos_y[31] ? 32'(-in_i.pos_y) : 32'(in_i.pos_y);
      nx1_q  <= in_i.pos_x[31];
      ny1_q  <= in_i.pos_y[31];
      fx1_q  <= in_i.force_x_in;
      fy1_q  <= in_i.force_y_in;

      sqx2_q <= ax1_q * ax1_q;
      sqy2_q <= ay1_q * ay1_q;
      px2_q  <= cmag_q * ay1_q;
      py2_q  <= cmag_q * ax1_q;
      ntx2_q <= rot_q[31] ^ ny1_q;
      nty2_q <= rot_q[31] ^ nx1_q;
      fx2_q  <= fx1_q;
      fy2_q  <= fy1_q;

      s3_q   <= sqx2_q + sqy2_q;
      px3_q  <= px2_q;
      py3_q  <= py2_q;
      ntx3_q <= ntx2_q;
      nty3_q <= nty2_q;
      fx3_q  <= fx2_q;
      fy3_q  <= fy2_q;
    end
  end

  arf_root_side_t rs_in, rs_out;
  logic           sq_v;
  logic [31:0]    root;

  always_comb begin
    rs_in.side.band   = (s3_q > in2_q) && (s3_q < out2_q);
    rs_in.side.neg_tx = ntx3_q;
    rs_in.side.neg_ty = nty3_q;
    rs_in.side.fx     = fx3_q;
    rs_in.side.fy     = fy3_q;
    rs_in.prod_x      = px3_q;
    rs_in.prod_y      = py3_q;
  end

  arf_isqrt #(
    .SideW($bits(arf_root_side_t))
  ) u_isqrt (
    .clk_i,
    .rst_ni,
    .en_i     (en),
    .valid_i  (v3_q),
    .rad_sq_i (s3_q),
    .side_i   (rs_in),
    .valid_o  (sq_v),
    .root_o   (root),
    .side_o   (rs_out)
  );

  logic        dv_v;
  logic [31:0] qx, qy;
  arf_side_t   ds;

  arf_div u_div (
    .clk_i,
    .rst_ni,
    .en_i      (en),
    .valid_i   (sq_v),
    .divisor_i (root),
    .dvd_x_i   (rs_out.prod_x),
    .dvd_y_i   (rs_out.prod_y),
    .side_i    (rs_out.side),
    .valid_o   (dv_v),
    .quo_x_o   (qx),
    .quo_y_o   (qy),
    .side_o    (ds)
  );

  // Final stage: apply the signed contributions and saturate.
  logic signed [33:0] tx, ty, sx, sy;
  logic signed [31:0] fx_d, fy_d;
  logic               clip_x, clip_y;

  localparam logic signed [33:0] SMax = 34'sd2147483647;
  localparam logic signed [33:0] SMin = -34'sd2147483648;

  always_comb begin
    tx = ds.neg_tx ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
    ty = ds.neg_ty ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
    sx = 34'(ds.fx) - tx;
    sy = 34'(ds.fy) + ty;
    clip_x = (sx > SMax) || (sx < SMin);
    clip_y = (sy > SMax) || (sy < SMin);
    fx_d = (sx > SMax) ? 32'sh7fffffff : (sx < SMin) ? 32'sh80000000 : sx[31:0];
    fy_d = (sy > SMax) ? 32'sh7fffffff : (sy < SMin) ? 32'sh80000000 : sy[31:0];
  end

  logic               out_v_q;
  logic signed [31:0] ofx_q, ofy_q;
  logic               oband_q, osat_q;

  assign en = !out_v_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ofx_q   <= ds.band ? fx_d : ds.fx;
      ofy_q   <= ds.band ? fy_d : ds.fy;
      oband_q <= ds.band;
      osat_q  <= ds.band && (clip_x || clip_y);
    end
  end

  assign in_i.ready        = en;
  assign out_o.valid       = out_v_q;
  assign out_o.force_x_out = ofx_q;
  assign out_o.force_y_out = ofy_q;
  assign out_o.in_band     = oband_q;
  assign out_o.saturated   = osat_q;
endmodule

[rtl/arf_isqrt.sv]
module arf_isqrt #(
  parameter int unsigned SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [63:0]      rad_sq_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [31:0]      root_o,
  output logic [SideW-1:0] side_o
);
  import arf_pkg::*;

  localparam int unsigned Steps = DataW;

  logic             v_q    [Steps+1];
  logic [63:0]      s_q    [Steps+1];
  logic [32:0]      rem_q  [Steps+1];
  logic [31:0]      root_q [Steps+1];
  logic [SideW-1:0] side_q [Steps+1];

  assign v_q[0]    = valid_i;
  assign s_q[0]    = rad_sq_i;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign side_q[0] = side_i;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [34:0] rem_t;
    logic [34:0] trial;
    logic        ge;
    logic [34:0] diff;

    assign rem_t = {rem_q[k], s_q[k][63:62]};
    assign trial = {1'b0, root_q[k], 2'b01};
    assign ge    = rem_t >= trial;
    assign diff  = rem_t - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[k+1]    <= {s_q[k][61:0], 2'b00};
        rem_q[k+1]  <= ge ? diff[32:0] : rem_t[32:0];
        root_q[k+1] <= {root_q[k][30:0], ge};
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = v_q[Steps];
  assign root_o  = root_q[Steps];
  assign side_o  = side_q[Steps];
endmodule

[rtl/arf_div.sv]
module arf_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [31:0]         divisor_i,
  input  logic [63:0]         dvd_x_i,
  input  logic [63:0]         dvd_y_i,
  input  arf_pkg::arf_side_t  side_i,
  output logic                valid_o,
  output logic [31:0]         quo_x_o,
  output logic [31:0]         quo_y_o,
  output arf_pkg::arf_side_t  side_o
);
  import arf_pkg::*;

  localparam int unsigned Steps = DataW;

  logic        v_q    [Steps+1];
  logic [31:0] d_q    [Steps+1];
  logic [31:0] rx_q   [Steps+1];
  logic [31:0] qx_q   [Steps+1];
  logic [31:0] ry_q   [Steps+1];
  logic [31:0] qy_q   [Steps+1];
  arf_side_t   side_q [Steps+1];

  assign v_q[0]    = valid_i;
  assign d_q[0]    = divisor_i;
  assign rx_q[0]   = dvd_x_i[63:32];
  assign qx_q[0]   = dvd_x_i[31:0];
  assign ry_q[0]   = dvd_y_i[63:32];
  assign qy_q[0]   = dvd_y_i[31:0];
  assign side_q[0] = side_i;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [32:0] tx, ty, dx, dy, dd;
    logic        gex, gey;

    assign dd  = {1'b0, d_q[k]};
    assign tx  = {rx_q[k], qx_q[k][31]};
    assign ty  = {ry_q[k], qy_q[k][31]};
    assign gex = tx >= dd;
    assign gey = ty >= dd;
    assign dx  = tx - dd;
    assign dy  = ty - dd;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[k+1]    <= d_q[k];
        rx_q[k+1]   <= gex ? dx[31:0] : tx[31:0];
        ry_q[k+1]   <= gey ? dy[31:0] : ty[31:0];
        qx_q[k+1]   <= {qx_q[k][30:0], gex};
        qy_q[k+1]   <= {qy_q[k][30:0], gey};
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = v_q[Steps];
  assign quo_x_o = qx_q[Steps];
  assign quo_y_o = qy_q[Steps];
  assign side_o  = side_q[Steps];
endmodule

[rtl/arf_checker.sv]
module arf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_fx_i,
  input logic [31:0] out_fy_i,
  input logic        out_band_i,
  input logic        out_sat_i
);

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("Output word valid during reset.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_fx_i)
      && $stable(out_fy_i) && $stable(out_band_i) && $stable(out_sat_i))
    else $error("Stalled output word changed.");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("Input ready does not follow the output stall.");

  a_sat_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_band_i |-> !out_sat_i)
    else $error("Saturation flagged outside the band.");

endmodule

bind annular_rotational_force arf_checker u_arf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_fx_i    (out_o.force_x_out),
  .out_fy_i    (out_o.force_y_out),
  .out_band_i  (out_o.in_band),
  .out_sat_i   (out_o.saturated)
);
